### src/fhrx_pkg.sv
`default_nettype none

package fhrx_pkg;

	// Field widths of the input and result words.
	localparam int ACT_W      = 2;
	localparam int FRAME_W    = 10;
	localparam int SLOT_W     = 8;
	localparam int SYM_W      = 4;
	localparam int VRD_W      = 3;
	localparam int DIST_W     = 20;
	localparam int TOTAL_W    = 32;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 120;

	// Configuration register widths.
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_W      = 14;
	localparam int NUM_W      = 3;
	localparam int SPS_W      = 4;
	localparam int WIN_W      = 14;

	// Action codes carried in the input tuser.
	localparam logic [ACT_W-1:0] ACT_OTA  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MSG  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	// Verdict codes carried in the output tuser.
	localparam logic [VRD_W-1:0] VRD_OTA     = 3'd0;
	localparam logic [VRD_W-1:0] VRD_ON_TIME = 3'd1;
	localparam logic [VRD_W-1:0] VRD_EARLY   = 3'd2;
	localparam logic [VRD_W-1:0] VRD_LATE    = 3'd3;
	localparam logic [VRD_W-1:0] VRD_READ    = 3'd4;

	// Register indexes on the configuration port.
	localparam logic [CFG_ADDR_W-1:0] REG_NUMEROLOGY = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SYMBOLS    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_WIN_START  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_WIN_END    = 2'd3;

	// Numerology is clamped to this value; symbols per slot is 12 or else 14.
	localparam logic [NUM_W-1:0] NUM_MAX     = 3'd4;
	localparam logic [NUM_W-1:0] NUM_RESET   = 3'd1;
	localparam logic [SPS_W-1:0] SPS_EXT     = 4'd12;
	localparam logic [SPS_W-1:0] SPS_RESET   = 4'd14;

	// The stored OTA index is under 19 wrap periods of any other setting,
	// so a five step restoring reduction brings it into range.
	localparam int FIX_STEPS  = 5;
	localparam int FIX_STEP_W = 3;

endpackage

`default_nettype wire

### src/fronthaul_rx_window_checker_unit.sv
// Fronthaul receive window checker. An OTA tick word (tuser action 0) stores
// the linear symbol index of frame, slot and symbol; a message word (action 1)
// forms its own index, takes the distance to the stored OTA index wrapped into
// half the wrap period, and is reported on time, early or late against
// window_start and window_end; a read word (action 2) returns the three
// saturating counters and clears them; action 3 is taken and dropped. The
// block accepts one word per clock cycle unless a stall reaches the input or a
// reduction holds s_axis_tready low. Eight pipeline stages form the index by
// constant multiplies and a compare-subtract, take the distance and check it
// against the window; then comes the output register, which lets the block
// keep accepting while a result waits. Any configuration write restarts a
// reduction of the stored OTA index into the current wrap period.
`default_nettype none

module fronthaul_rx_window_checker_unit #(
	parameter int FRAME_WRAP    = 256,
	parameter int COUNTER_WIDTH = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [fhrx_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [fhrx_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// frame_number [9:0], slot_number [17:10], symbol_number [21:18]
	input  wire logic [fhrx_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// action [1:0]
	input  wire logic [fhrx_pkg::ACT_W-1:0]         s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// accepted [0], distance [20:1], on_time_total [52:21],
	// early_total [84:53], late_total [116:85]
	output logic [fhrx_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	// verdict [2:0]
	output logic [fhrx_pkg::VRD_W-1:0]              m_axis_tuser
);

	localparam int NSTG    = 8;
	localparam int FM_W    = $clog2(FRAME_WRAP);
	localparam int FSUM_W  = 11;
	localparam int Q10_W   = 5;
	localparam int REM_W   = 4;
	localparam int RCP_S   = FSUM_W + $clog2(FRAME_WRAP);
	localparam int RCP_M   = ((1 << RCP_S) + FRAME_WRAP - 1) / FRAME_WRAP;
	localparam int RCP_M_W = $clog2(RCP_M + 1);
	localparam int RCP_P_W = FSUM_W + RCP_M_W;
	localparam int LS_W    = $clog2(FRAME_WRAP * 160);
	localparam int LIN_W   = $clog2(FRAME_WRAP * 2240 + 16);
	localparam int IDX_W   = $clog2(FRAME_WRAP * 2240 + 1);
	localparam int D_W     = IDX_W + 1;
	localparam int CMP_W   = (D_W > fhrx_pkg::WIN_W + 1) ? D_W : fhrx_pkg::WIN_W + 1;
	localparam int DX_W    = (D_W > fhrx_pkg::DIST_W) ? D_W : fhrx_pkg::DIST_W;
	localparam int CX_W    = (COUNTER_WIDTH > fhrx_pkg::TOTAL_W) ? COUNTER_WIDTH
	                                                             : fhrx_pkg::TOTAL_W;
	localparam int FIX_W   = IDX_W + fhrx_pkg::FIX_STEPS - 1;
	localparam int WRAP12  = FRAME_WRAP * 120;
	localparam int WRAP14  = FRAME_WRAP * 140;

	// Configuration registers.
	logic [fhrx_pkg::NUM_W-1:0] numerology_q;
	logic [fhrx_pkg::SPS_W-1:0] sps_q;
	logic [fhrx_pkg::WIN_W-1:0] win_start_q;
	logic [fhrx_pkg::WIN_W-1:0] win_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerology_q <= fhrx_pkg::NUM_RESET;
			sps_q        <= fhrx_pkg::SPS_RESET;
			win_start_q  <= '0;
			win_end_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				fhrx_pkg::REG_NUMEROLOGY: numerology_q <= cfg_data[fhrx_pkg::NUM_W-1:0];
				fhrx_pkg::REG_SYMBOLS:    sps_q        <= cfg_data[fhrx_pkg::SPS_W-1:0];
				fhrx_pkg::REG_WIN_START:  win_start_q  <= cfg_data[fhrx_pkg::WIN_W-1:0];
				fhrx_pkg::REG_WIN_END:    win_end_q    <= cfg_data[fhrx_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective numerology, cyclic prefix choice and the wrap period.
	logic [fhrx_pkg::NUM_W-1:0] num_eff;
	logic                       sps_norm;
	logic [IDX_W-1:0]           wrap;
	logic [IDX_W-1:0]           half;

	assign num_eff  = (numerology_q > fhrx_pkg::NUM_MAX) ? fhrx_pkg::NUM_MAX : numerology_q;
	assign sps_norm = (sps_q != fhrx_pkg::SPS_EXT);
	assign wrap     = (sps_norm ? IDX_W'(WRAP14) : IDX_W'(WRAP12)) << num_eff;
	assign half     = wrap >> 1;

	// Pipeline handshake: a stage loads when it is empty or the next one moves.
	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] en;
	logic            out_valid_q;
	logic            fix_busy_q;
	logic            in_acc;

	always_comb begin
		en[NSTG+1] = !out_valid_q || m_axis_tready;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_axis_tready = en[1] && !fix_busy_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_acc && (s_axis_tuser != fhrx_pkg::ACT_NONE);
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (en[NSTG+1]) begin
				out_valid_q <= vld_q[NSTG];
			end
		end
	end

	// Stage 1: input register; divide the shifted slot by ten.
	logic [fhrx_pkg::ACT_W-1:0]   act_s1;
	logic [fhrx_pkg::FRAME_W-1:0] frame_s1;
	logic [fhrx_pkg::SLOT_W-1:0]  slot_s1;
	logic [fhrx_pkg::SYM_W-1:0]   sym_s1;
	logic [fhrx_pkg::SLOT_W-1:0]  sh1;
	logic [Q10_W-1:0]             q10_1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			act_s1   <= s_axis_tuser;
			frame_s1 <= s_axis_tdata[9:0];
			slot_s1  <= s_axis_tdata[17:10];
			sym_s1   <= s_axis_tdata[21:18];
		end
	end

	assign sh1   = slot_s1 >> num_eff;
	assign q10_1 = Q10_W'((16'(sh1) * 16'd205) >> 11);

	// Stage 2: carry slot overflow into the frame, divide by the frame wrap.
	logic [fhrx_pkg::ACT_W-1:0]   act_s2;
	logic [fhrx_pkg::FRAME_W-1:0] frame_s2;
	logic [fhrx_pkg::SLOT_W-1:0]  slot_s2;
	logic [fhrx_pkg::SYM_W-1:0]   sym_s2;
	logic [Q10_W-1:0]             q10_s2;
	logic [FSUM_W-1:0]            fsum2;
	logic [FSUM_W-1:0]            qw2;
	logic [fhrx_pkg::SLOT_W-1:0]  sh2;
	logic [REM_W-1:0]             rem10_2;
	logic [fhrx_pkg::SLOT_W:0]    lowmask2;
	logic [fhrx_pkg::SLOT_W-1:0]  slot_rem2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			act_s2   <= act_s1;
			frame_s2 <= frame_s1;
			slot_s2  <= slot_s1;
			sym_s2   <= sym_s1;
			q10_s2   <= q10_1;
		end
	end

	assign fsum2     = FSUM_W'(frame_s2) + FSUM_W'(q10_s2);
	assign qw2       = FSUM_W'((RCP_P_W'(fsum2) * RCP_P_W'(RCP_M)) >> RCP_S);
	assign sh2       = slot_s2 >> num_eff;
	assign rem10_2   = REM_W'(sh2 - fhrx_pkg::SLOT_W'(fhrx_pkg::SLOT_W'(q10_s2) * 8'd10));
	assign lowmask2  = (9'd1 << num_eff) - 9'd1;
	assign slot_rem2 = fhrx_pkg::SLOT_W'({4'd0, rem10_2} << num_eff)
	                 | (slot_s2 & lowmask2[fhrx_pkg::SLOT_W-1:0]);

	// Stage 3: frame remainder.
	logic [fhrx_pkg::ACT_W-1:0]   act_s3;
	logic [FSUM_W-1:0]            fsum_s3;
	logic [FSUM_W-1:0]            qw_s3;
	logic [fhrx_pkg::SLOT_W-1:0]  slot_rem_s3;
	logic [fhrx_pkg::SYM_W-1:0]   sym_s3;
	logic [FSUM_W-1:0]            fm_full3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			act_s3      <= act_s2;
			fsum_s3     <= fsum2;
			qw_s3       <= qw2;
			slot_rem_s3 <= slot_rem2;
			sym_s3      <= sym_s2;
		end
	end

	assign fm_full3 = fsum_s3 - FSUM_W'(qw_s3 * FSUM_W'(FRAME_WRAP));

	// Stage 4: slot index within the wrap period.
	logic [fhrx_pkg::ACT_W-1:0]   act_s4;
	logic [FM_W-1:0]              fm_s4;
	logic [fhrx_pkg::SLOT_W-1:0]  slot_rem_s4;
	logic [fhrx_pkg::SYM_W-1:0]   sym_s4;
	logic [LS_W-1:0]              lin_slot4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			act_s4      <= act_s3;
			fm_s4       <= fm_full3[FM_W-1:0];
			slot_rem_s4 <= slot_rem_s3;
			sym_s4      <= sym_s3;
		end
	end

	assign lin_slot4 = LS_W'((LS_W'(fm_s4) * LS_W'(10)) << num_eff) + LS_W'(slot_rem_s4);

	// Stage 5: symbol index, times 12 or 14 by shifts.
	logic [fhrx_pkg::ACT_W-1:0]   act_s5;
	logic [LS_W-1:0]              lin_slot_s5;
	logic [fhrx_pkg::SYM_W-1:0]   sym_s5;
	logic [LIN_W-1:0]             x5;
	logic [LIN_W-1:0]             lin5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			act_s5      <= act_s4;
			lin_slot_s5 <= lin_slot4;
			sym_s5      <= sym_s4;
		end
	end

	assign x5   = LIN_W'(lin_slot_s5);
	assign lin5 = (sps_norm ? ((x5 << 4) - (x5 << 1)) : ((x5 << 3) + (x5 << 2)))
	            + LIN_W'(sym_s5);

	// Stage 6: an oversized symbol number spills past the wrap at most once.
	logic [fhrx_pkg::ACT_W-1:0]   act_s6;
	logic [LIN_W-1:0]             lin_s6;
	logic [LIN_W-1:0]             idx_full6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			act_s6 <= act_s5;
			lin_s6 <= lin5;
		end
	end

	assign idx_full6 = (lin_s6 >= LIN_W'(wrap)) ? lin_s6 - LIN_W'(wrap) : lin_s6;

	// Stage 7: distance to the OTA index, wrapped into half a period.
	logic [fhrx_pkg::ACT_W-1:0]   act_s7;
	logic [IDX_W-1:0]             idx_s7;
	logic [IDX_W-1:0]             ota_q;
	logic [IDX_W-1:0]             ota_raw_q;
	logic signed [D_W-1:0]        draw7;
	logic signed [D_W-1:0]        wrap_sg;
	logic signed [D_W-1:0]        half_sg;
	logic signed [D_W-1:0]        d7;
	logic                         ota_wr;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			act_s7 <= act_s6;
			idx_s7 <= idx_full6[IDX_W-1:0];
		end
	end

	assign wrap_sg = $signed({1'b0, wrap});
	assign half_sg = $signed({1'b0, half});
	assign draw7   = $signed({1'b0, idx_s7}) - $signed({1'b0, ota_q});

	always_comb begin
		if (draw7 >= half_sg) begin
			d7 = draw7 - wrap_sg;
		end else if (draw7 < -half_sg) begin
			d7 = draw7 + wrap_sg;
		end else begin
			d7 = draw7;
		end
	end

	assign ota_wr = vld_q[7] && en[8] && (act_s7 == fhrx_pkg::ACT_OTA);

	// OTA index: a tick stores it; a configuration write restarts a restoring
	// reduction of the tick's index into the new wrap period.
	logic [fhrx_pkg::FIX_STEP_W-1:0] fix_step_q;
	logic [FIX_W-1:0]                fix_sub;

	assign fix_sub = FIX_W'(wrap) << fix_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ota_q      <= '0;
			ota_raw_q  <= '0;
			fix_busy_q <= 1'b0;
			fix_step_q <= '0;
		end else begin
			if (ota_wr) begin
				ota_raw_q <= idx_s7;
			end
			if (cfg_we) begin
				ota_q      <= ota_raw_q;
				fix_busy_q <= 1'b1;
				fix_step_q <= fhrx_pkg::FIX_STEP_W'(fhrx_pkg::FIX_STEPS - 1);
			end else if (fix_busy_q) begin
				if (FIX_W'(ota_q) >= fix_sub) begin
					ota_q <= IDX_W'(FIX_W'(ota_q) - fix_sub);
				end
				if (fix_step_q == '0) begin
					fix_busy_q <= 1'b0;
				end else begin
					fix_step_q <= fix_step_q - 1'b1;
				end
			end else if (ota_wr) begin
				ota_q <= idx_s7;
			end
		end
	end

	// Stage 8: window compare, counters and the result word.
	logic [fhrx_pkg::ACT_W-1:0]   act_s8;
	logic signed [D_W-1:0]        d_s8;
	logic signed [CMP_W-1:0]      dc8;
	logic signed [CMP_W-1:0]      ws8;
	logic signed [CMP_W-1:0]      we8;
	logic signed [DX_W-1:0]       dx8;
	logic                         early8;
	logic                         late8;
	logic                         adv8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			act_s8 <= act_s7;
			d_s8   <= d7;
		end
	end

	assign dc8    = CMP_W'(d_s8);
	assign ws8    = $signed(CMP_W'({1'b0, win_start_q}));
	assign we8    = $signed(CMP_W'({1'b0, win_end_q}));
	assign dx8    = DX_W'(d_s8);
	assign early8 = dc8 > we8;
	assign late8  = dc8 < ws8;
	assign adv8   = vld_q[NSTG] && en[NSTG+1];

	logic [COUNTER_WIDTH-1:0] on_cnt_q;
	logic [COUNTER_WIDTH-1:0] early_cnt_q;
	logic [COUNTER_WIDTH-1:0] late_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_cnt_q    <= '0;
			early_cnt_q <= '0;
			late_cnt_q  <= '0;
		end else if (adv8) begin
			if (act_s8 == fhrx_pkg::ACT_MSG) begin
				if (early8) begin
					early_cnt_q <= (early_cnt_q == '1) ? early_cnt_q : early_cnt_q + 1'b1;
				end else if (late8) begin
					late_cnt_q <= (late_cnt_q == '1) ? late_cnt_q : late_cnt_q + 1'b1;
				end else begin
					on_cnt_q <= (on_cnt_q == '1) ? on_cnt_q : on_cnt_q + 1'b1;
				end
			end else if (act_s8 == fhrx_pkg::ACT_READ) begin
				on_cnt_q    <= '0;
				early_cnt_q <= '0;
				late_cnt_q  <= '0;
			end
		end
	end

	// Result word contents for the item in stage 8.
	logic [fhrx_pkg::VRD_W-1:0]   vrd8;
	logic                         acc8;
	logic [fhrx_pkg::DIST_W-1:0]  dist8;
	logic [fhrx_pkg::TOTAL_W-1:0] on_tot8;
	logic [fhrx_pkg::TOTAL_W-1:0] early_tot8;
	logic [fhrx_pkg::TOTAL_W-1:0] late_tot8;
	logic [CX_W-1:0]              on_x8;
	logic [CX_W-1:0]              early_x8;
	logic [CX_W-1:0]              late_x8;

	assign on_x8    = CX_W'(on_cnt_q);
	assign early_x8 = CX_W'(early_cnt_q);
	assign late_x8  = CX_W'(late_cnt_q);

	always_comb begin
		vrd8       = fhrx_pkg::VRD_OTA;
		acc8       = 1'b0;
		dist8      = '0;
		on_tot8    = '0;
		early_tot8 = '0;
		late_tot8  = '0;
		case (act_s8)
			fhrx_pkg::ACT_MSG: begin
				dist8 = dx8[fhrx_pkg::DIST_W-1:0];
				if (early8) begin
					vrd8 = fhrx_pkg::VRD_EARLY;
				end else if (late8) begin
					vrd8 = fhrx_pkg::VRD_LATE;
				end else begin
					vrd8 = fhrx_pkg::VRD_ON_TIME;
					acc8 = 1'b1;
				end
			end
			fhrx_pkg::ACT_READ: begin
				vrd8       = fhrx_pkg::VRD_READ;
				on_tot8    = on_x8[fhrx_pkg::TOTAL_W-1:0];
				early_tot8 = early_x8[fhrx_pkg::TOTAL_W-1:0];
				late_tot8  = late_x8[fhrx_pkg::TOTAL_W-1:0];
			end
			default: ;
		endcase
	end

	// Output register.
	logic [fhrx_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [fhrx_pkg::VRD_W-1:0]      out_vrd_q;

	always_ff @(posedge clk) begin
		if (en[NSTG+1]) begin
			out_vrd_q  <= vrd8;
			out_data_q <= {3'd0, late_tot8, early_tot8, on_tot8, dist8, acc8};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_vrd_q;

	// A configuration write always holds off input for the reduction.
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_axis_tready)
		else $error("input taken right after a configuration write");

	// A read leaves all three counters cleared.
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv8 && act_s8 == fhrx_pkg::ACT_READ) |=>
		(on_cnt_q == '0 && early_cnt_q == '0 && late_cnt_q == '0))
		else $error("counters not cleared by a read");

	// The accepted flag matches the on-time verdict on every result word.
	a_accept_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tuser == fhrx_pkg::VRD_ON_TIME)))
		else $error("accepted flag disagrees with verdict");

	// A read word carries no distance.
	a_read_no_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == fhrx_pkg::VRD_READ) |-> (m_axis_tdata[20:1] == '0))
		else $error("read word carries a distance");

endmodule

`default_nettype wire
